// File: sv/assert_macros.svh
// Assertion macros used by the route discovery wait table top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");
`endif

// File: sv/rdwt_pkg.sv
// Package with types and constants of the route discovery wait table.
package rdwt_pkg;
    localparam int TABLE_SLOTS = 16;
    localparam int ROUTE_BYTES = 8;
    localparam int IDX_W = $clog2(TABLE_SLOTS);
    localparam int CNT_W = $clog2(TABLE_SLOTS + 1);

    typedef enum logic [1:0] {CMD_REQ = 2'd0, CMD_TICK = 2'd1, CMD_REPLY = 2'd2,
        CMD_CLEAN = 2'd3} cmd_t;
    typedef enum logic [1:0] {ST_FREE = 2'd0, ST_LOCAL = 2'd1, ST_REMOTE = 2'd2,
        ST_DONE = 2'd3} slot_st_t;
    typedef enum logic [2:0] {EV_QUEUED = 3'd0, EV_NEW = 3'd1, EV_FULL = 3'd2,
        EV_REMOTE = 3'd3, EV_UNKNOWN = 3'd4, EV_KNOWN = 3'd5, EV_NOMATCH = 3'd6,
        EV_FREED = 3'd7} event_t;
    typedef enum logic [2:0] {FS_IDLE, FS_READ, FS_SCAN, FS_FINAL, FS_WAIT} fsm_t;
    localparam logic REG_LOCAL = 1'b0;
    localparam logic REG_REMOTE = 1'b1;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] timer;
        logic [47:0] mac;
        logic [7:0]  stream;
    } slot_t;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [3:0]  entry_index;
        logic [47:0] out_mac;
        logic [7:0]  out_stream;
        logic [63:0] out_route;
        logic [3:0]  out_route_len;
        logic        route_too_long;
        logic        last;
    } result_t;
endpackage

// File: sv/rdwt_out_buf.sv
// Two-entry result buffer that separates the table scan from the output stream.
module rdwt_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  rdwt_pkg::result_t push_data,
    output logic              space,
    output logic              m_tvalid,
    input  logic              m_tready,
    output rdwt_pkg::result_t m_data
);
    import rdwt_pkg::*;

    result_t     mem_reg [2];
    logic        wr_reg, rd_reg;
    logic [1:0]  cnt_reg;
    logic        pop;

    assign pop = m_tvalid && m_tready;
    assign m_tvalid = (cnt_reg != 2'd0);
    // Space depends on the count alone so that the writer may gate its push with it.
    assign space = (cnt_reg != 2'd2);
    assign m_data = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= 1'b0;
            rd_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wr_reg <= ~wr_reg;
            if (pop)
                rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

// File: sv/route_discovery_wait_table.sv
// Top level of the route discovery wait table.
// Channel   Dir  Handshake          Content
// s_axis    in   tvalid/tready      one command item
// m_axis    out  tvalid/tready      one result item, tlast on the final one
// cfg       in   cfg_valid/ready    register index and 16-bit value
// A command reads one slot per cycle from the slot memory, while the result buffer has
// space, and writes back each slot that it changes. A held tick returns to idle from
// the read state without a scan.
// Reset clears slot status through a valid bit per slot; other fields need none.
// A full result buffer stalls the scan; input is taken again once idle.
module route_discovery_wait_table (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // mac_addr, stream_id, route_data, route_len
    input  logic [2:0]   s_axis_tuser,  // cmd, tick_hold
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [135:0] m_axis_tdata,  // entry_index, out_mac, out_stream, out_route,
                                        // out_route_len, route_too_long
    output logic [2:0]   m_axis_tuser,  // event_res
    output logic         m_axis_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [15:0]  cfg_data
);
    import rdwt_pkg::*;
    `include "assert_macros.svh"

    slot_t       slot_mem [TABLE_SLOTS];
    logic [63:0] route_mem [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0] valid_reg;
    slot_t       rd_slot;
    logic [15:0] local_reg, remote_reg;
    fsm_t        state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic        idx_end;
    logic [1:0]  cmd_reg;
    logic        hold_reg;
    logic [47:0] mac_reg;
    logic [7:0]  stream_reg;
    logic [63:0] route_reg;
    logic [3:0]  rlen_reg;
    logic        free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic        done_reg, done_next;
    logic [4:0]  nres_reg, nres_next;
    logic [CNT_W-1:0] pend_reg, pend_next;
    result_t     pend_res_reg, pend_res_next, res_out;
    logic        have_reg, have_next;
    logic        push, space;
    result_t     push_data;
    logic        wr_en;
    slot_t       wr_slot;
    logic        wr_route;
    logic [63:0] kept;
    logic [3:0]  keep_n;
    logic        too_long;
    logic        ev_valid;
    result_t     ev;
    slot_st_t    st;

    assign s_axis_tready = (state_reg == FS_IDLE);
    assign cfg_ready = 1'b1;
    assign idx_end = (idx_reg == IDX_W'(TABLE_SLOTS - 1));
    assign st = valid_reg[idx_reg] ? slot_st_t'(rd_slot.status) : ST_FREE;

    always_comb
    begin
        too_long = (rlen_reg > 4'(ROUTE_BYTES));
        keep_n = too_long ? 4'(ROUTE_BYTES) : rlen_reg;
        for (int b = 0; b < 8; b++)
            kept[b*8 +: 8] = (4'(b) < keep_n) ? route_reg[b*8 +: 8] : 8'h00;
    end

    // Per-slot decision during the scan, and the closing result in the final state.
    always_comb
    begin
        ev_valid = 1'b0;
        ev = '0;
        ev.entry_index = 4'(idx_reg);
        ev.out_mac = rd_slot.mac;
        ev.out_stream = rd_slot.stream;
        wr_en = 1'b0;
        wr_slot = rd_slot;
        wr_route = 1'b0;
        free_found_next = free_found_reg;
        free_idx_next = free_idx_reg;
        done_next = done_reg;
        pend_next = pend_reg;
        if (state_reg == FS_SCAN && !done_reg)
        begin
            case (cmd_t'(cmd_reg))
                CMD_REQ:
                begin
                    if (st == ST_FREE)
                    begin
                        if (!free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next = idx_reg;
                        end
                    end
                    else if (rd_slot.mac == mac_reg)
                    begin
                        ev_valid = 1'b1;
                        ev.event_res = EV_QUEUED;
                        done_next = 1'b1;
                    end
                end
                CMD_TICK:
                begin
                    if (st == ST_LOCAL || st == ST_REMOTE)
                    begin
                        wr_en = 1'b1;
                        if (rd_slot.timer > 16'd1)
                            wr_slot.timer = rd_slot.timer - 16'd1;
                        else if (st == ST_LOCAL)
                        begin
                            wr_slot.status = ST_REMOTE;
                            wr_slot.timer = remote_reg;
                            ev_valid = 1'b1;
                            ev.event_res = EV_REMOTE;
                        end
                        else
                        begin
                            wr_slot.status = ST_DONE;
                            wr_slot.timer = 16'd0;
                            ev_valid = 1'b1;
                            ev.event_res = EV_UNKNOWN;
                        end
                    end
                end
                CMD_REPLY:
                begin
                    if ((st == ST_LOCAL || st == ST_REMOTE) && rd_slot.mac == mac_reg)
                    begin
                        wr_en = 1'b1;
                        wr_route = 1'b1;
                        wr_slot.status = ST_DONE;
                        wr_slot.timer = 16'd0;
                        ev_valid = 1'b1;
                        ev.event_res = EV_KNOWN;
                        ev.out_route = kept;
                        ev.out_route_len = keep_n;
                        ev.route_too_long = too_long;
                        done_next = 1'b1;
                    end
                end
                default:
                begin
                    if (st != ST_FREE && rd_slot.stream == stream_reg)
                    begin
                        wr_en = 1'b1;
                        wr_slot.status = ST_FREE;
                        wr_slot.timer = 16'd0;
                        if (pend_reg != '0)
                            pend_next = pend_reg - CNT_W'(1);
                        ev_valid = 1'b1;
                        ev.event_res = EV_FREED;
                    end
                end
            endcase
        end
        else if (state_reg == FS_FINAL && !done_reg)
        begin
            ev.entry_index = 4'd0;
            ev.out_mac = mac_reg;
            ev.out_stream = 8'd0;
            case (cmd_t'(cmd_reg))
                CMD_REQ:
                begin
                    ev_valid = 1'b1;
                    ev.out_stream = stream_reg;
                    if (free_found_reg)
                    begin
                        ev.event_res = EV_NEW;
                        ev.entry_index = 4'(free_idx_reg);
                        wr_en = 1'b1;
                        wr_slot.status = ST_LOCAL;
                        wr_slot.timer = local_reg;
                        wr_slot.mac = mac_reg;
                        wr_slot.stream = stream_reg;
                        pend_next = pend_reg + CNT_W'(1);
                    end
                    else
                        ev.event_res = EV_FULL;
                end
                CMD_REPLY:
                begin
                    ev_valid = 1'b1;
                    ev.event_res = EV_NOMATCH;
                end
                default:
                    ev_valid = 1'b0;
            endcase
        end
    end

    // One result is held back so that the final one can carry the last flag.
    always_comb
    begin
        push = 1'b0;
        push_data = pend_res_reg;
        pend_res_next = pend_res_reg;
        have_next = have_reg;
        nres_next = nres_reg;
        if (ev_valid && nres_reg < 5'd16)
        begin
            push = have_reg;
            pend_res_next = ev;
            have_next = 1'b1;
            nres_next = nres_reg + 5'd1;
        end
        else if (state_reg == FS_WAIT && have_reg)
        begin
            push = 1'b1;
            push_data.last = 1'b1;
            have_next = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        case (state_reg)
            FS_IDLE:
                if (s_axis_tvalid)
                    state_next = FS_READ;
            FS_READ:
                if (cmd_t'(cmd_reg) == CMD_TICK && hold_reg)
                    state_next = FS_IDLE;
                else
                    state_next = FS_SCAN;
            FS_SCAN:
                if (space)
                begin
                    idx_next = idx_reg + IDX_W'(1);
                    if (idx_end || done_next)
                        state_next = FS_FINAL;
                end
            FS_FINAL:
                if (space)
                    state_next = FS_WAIT;
            FS_WAIT:
                if (!have_reg || space)
                    state_next = FS_IDLE;
            default:
                state_next = FS_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        rd_slot <= slot_mem[(state_reg == FS_SCAN && space) ? idx_next : idx_reg];
        if (wr_en && space && (state_reg == FS_SCAN))
            slot_mem[idx_reg] <= wr_slot;
        else if (wr_en && space && (state_reg == FS_FINAL))
            slot_mem[free_idx_reg] <= wr_slot;
        if (wr_route && space)
            route_mem[idx_reg] <= kept;
        if (state_reg == FS_IDLE)
        begin
            cmd_reg <= s_axis_tuser[1:0];
            hold_reg <= s_axis_tuser[2];
            mac_reg <= s_axis_tdata[47:0];
            stream_reg <= s_axis_tdata[55:48];
            route_reg <= s_axis_tdata[119:56];
            rlen_reg <= s_axis_tdata[123:120];
        end
        if (space)
            pend_res_reg <= pend_res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FS_IDLE;
            idx_reg <= '0;
            valid_reg <= '0;
            local_reg <= 16'd3;
            remote_reg <= 16'd3;
            free_found_reg <= 1'b0;
            free_idx_reg <= '0;
            done_reg <= 1'b0;
            nres_reg <= '0;
            pend_reg <= '0;
            have_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_index == REG_LOCAL)
                local_reg <= cfg_data;
            if (cfg_valid && cfg_index == REG_REMOTE)
                remote_reg <= cfg_data;
            if (state_reg == FS_IDLE)
            begin
                idx_reg <= '0;
                free_found_reg <= 1'b0;
                done_reg <= 1'b0;
                nres_reg <= '0;
            end
            else if (space || state_reg == FS_READ || (state_reg == FS_WAIT && !have_reg))
            begin
                state_reg <= state_next;
                idx_reg <= (state_reg == FS_SCAN) ? idx_next : idx_reg;
                free_found_reg <= free_found_next;
                free_idx_reg <= free_idx_next;
                done_reg <= done_next;
                nres_reg <= nres_next;
                pend_reg <= pend_next;
                have_reg <= have_next;
                if (wr_en && state_reg == FS_SCAN)
                    valid_reg[idx_reg] <= 1'b1;
                else if (wr_en && state_reg == FS_FINAL)
                    valid_reg[free_idx_reg] <= 1'b1;
            end
            if (state_reg == FS_IDLE)
                state_reg <= state_next;
        end
    end

    rdwt_out_buf u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push && space),
        .push_data(push_data),
        .space    (space),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_data   (res_out)
    );

    assign m_axis_tuser = res_out.event_res;
    assign m_axis_tlast = res_out.last;
    assign m_axis_tdata = {7'd0, res_out.route_too_long, res_out.out_route_len,
        res_out.out_route, res_out.out_stream, res_out.out_mac, res_out.entry_index};

    `ASSERT_IMPL(a_idle_no_held, clk, rst_n, state_reg == FS_IDLE, !have_reg)
    `ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, nres_reg <= 5'd16)
    `ASSERT_NEXT(a_accept_read, clk, rst_n, s_axis_tvalid && s_axis_tready, state_reg == FS_READ)
    `ASSERT_IMPL(a_pend_bound, clk, rst_n, 1'b1, pend_reg <= CNT_W'(TABLE_SLOTS))
endmodule
